>>> hw/rtl/wsd_pkg.sv
// Shared constants and types of the work-stealing deque.
// Depends on nothing; every other file of the block imports it.
package wsd_pkg;

	localparam int MAX_ORDERS = 11;
	localparam int RING_AW    = MAX_ORDERS - 1;
	localparam int ORDER_W    = $clog2(MAX_ORDERS);
	localparam int IDX_W      = 32;
	localparam int WORD_W     = 64;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;
	localparam int CNT_W      = 10;
	localparam int ORD_OUT_W  = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
	localparam logic [OP_W-1:0] OP_POP   = 2'd1;
	localparam logic [OP_W-1:0] OP_STEAL = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                 wr;
		logic                 rd;
		logic [RING_AW-1:0]   addr;
		logic [WORD_W-1:0]    word;
		logic [STATUS_W-1:0]  status;
		logic [CNT_W-1:0]     count;
		logic [ORD_OUT_W-1:0] order;
	} wsd_cmd_t;

endpackage

>>> hw/rtl/wsd_req_if.sv
// Request channel of the deque: one operation per word.
// Depends on wsd_pkg.
interface wsd_req_if;
	import wsd_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [WORD_W-1:0]   value_in;

	modport source (output valid, output opcode, output value_in, input ready);
	modport sink (input valid, input opcode, input value_in, output ready);
endinterface

>>> hw/rtl/wsd_rsp_if.sv
// Response channel of the deque: one result word per operation.
// Depends on wsd_pkg.
interface wsd_rsp_if;
	import wsd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [WORD_W-1:0]    value_out;
	logic [CNT_W-1:0]     item_count;
	logic [ORD_OUT_W-1:0] current_order;

	modport source (output valid, output status, output value_out, output item_count,
		output current_order, input ready);
	modport sink (input valid, input status, input value_out, input item_count,
		input current_order, output ready);
endinterface

>>> hw/rtl/wsd_front.sv
// Front part: accepts operations, keeps the top, bottom and order registers
// and turns each operation into a ring command. Depends on wsd_pkg, wsd_req_if.
module wsd_front (
	input  logic              clk,
	input  logic              arst_n,
	wsd_req_if.sink           req,
	output logic              cmd_valid,
	output wsd_pkg::wsd_cmd_t cmd,
	input  logic              cmd_ready
);
	import wsd_pkg::*;

	logic [IDX_W-1:0]   top_q, bot_q, top_d, bot_d, held, limit;
	logic [ORDER_W-1:0] order_q, order_d;
	logic               wr, rd;
	logic [IDX_W-1:0]   addr_full, new_cnt;
	logic [STATUS_W-1:0] status;
	logic               accept;

	assign accept    = req.valid && cmd_ready;
	assign req.ready = cmd_ready;
	assign held      = bot_q - top_q;
	assign limit     = (IDX_W'(1) << order_q) - IDX_W'(1);

	always_comb begin
		top_d     = top_q;
		bot_d     = bot_q;
		order_d   = order_q;
		wr        = 1'b0;
		rd        = 1'b0;
		addr_full = bot_q;
		status    = ST_OK;
		case (req.opcode)
			OP_PUSH: begin
				if (held >= limit && (32'(order_q) + 32'd1) >= 32'(MAX_ORDERS)) begin
					status = ST_FULL;
				end else begin
					if (held >= limit) begin
						order_d = order_q + ORDER_W'(1);
					end
					wr    = 1'b1;
					bot_d = bot_q + IDX_W'(1);
				end
			end
			OP_POP: begin
				if (held == '0) begin
					status = ST_EMPTY;
				end else begin
					rd        = 1'b1;
					addr_full = bot_q - IDX_W'(1);
					if (held > IDX_W'(1)) begin
						bot_d = bot_q - IDX_W'(1);
					end else begin
						top_d = top_q + IDX_W'(1);
						bot_d = top_q + IDX_W'(1);
					end
				end
			end
			OP_STEAL: begin
				if (held == '0) begin
					status = ST_EMPTY;
				end else begin
					rd        = 1'b1;
					addr_full = top_q;
					top_d     = top_q + IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign new_cnt = bot_d - top_d;

	always_comb begin
		cmd_valid  = req.valid;
		cmd.wr     = wr;
		cmd.rd     = rd;
		cmd.addr   = addr_full[RING_AW-1:0];
		cmd.word   = req.value_in;
		cmd.status = status;
		cmd.count  = new_cnt[CNT_W-1:0];
		cmd.order  = ORD_OUT_W'(order_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= '0;
			bot_q   <= '0;
			order_q <= '0;
		end else if (accept) begin
			top_q   <= top_d;
			bot_q   <= bot_d;
			order_q <= order_d;
		end
	end
endmodule

>>> hw/rtl/wsd_queue.sv
// Short command queue between the front and back parts.
// Depends on wsd_pkg.
module wsd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  wsd_pkg::wsd_cmd_t push_cmd,
	output logic              push_ready,
	output logic              pop_valid,
	output wsd_pkg::wsd_cmd_t pop_cmd,
	input  logic              pop_ready
);
	import wsd_pkg::*;

	wsd_cmd_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end
endmodule

>>> hw/rtl/wsd_back.sv
// Back part: owns the ring store, carries out writes and reads in order and
// holds the result word. Depends on wsd_pkg, wsd_rsp_if.
module wsd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  wsd_pkg::wsd_cmd_t cmd,
	output logic              cmd_ready,
	wsd_rsp_if.source         rsp
);
	import wsd_pkg::*;

	logic [WORD_W-1:0]    ring_q [1 << RING_AW];
	logic [WORD_W-1:0]    rd_data_s1;
	logic                 valid_s1, rd_s1;
	logic [STATUS_W-1:0]  status_s1;
	logic [CNT_W-1:0]     count_s1;
	logic [ORD_OUT_W-1:0] order_s1;
	logic                 take;

	assign cmd_ready = !valid_s1 || rsp.ready;
	assign take      = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (take) begin
			if (cmd.wr) begin
				ring_q[cmd.addr] <= cmd.word;
			end
			rd_data_s1 <= ring_q[cmd.addr];
			rd_s1      <= cmd.rd;
			status_s1  <= cmd.status;
			count_s1   <= cmd.count;
			order_s1   <= cmd.order;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	assign rsp.valid         = valid_s1;
	assign rsp.status        = status_s1;
	assign rsp.value_out     = rd_s1 ? rd_data_s1 : '0;
	assign rsp.item_count    = count_s1;
	assign rsp.current_order = order_s1;
endmodule

>>> hw/rtl/work_stealing_deque.sv
// Channel  Role    Words
// req      sink    opcode, value_in
// rsp      source  status, value_out, item_count, current_order
//
// One operation is accepted per cycle while the two-entry command queue has room.
// A result appears in the cycle after its command leaves the queue, set by the
// registered read of the ring store; a request passes the queue, then the output register.
// Reset clears the counters, the order and all valid state; the ring needs no clearing.
// A stalled result holds in the output register while the queue absorbs new requests.
module work_stealing_deque (
	input  logic      clk,
	input  logic      arst_n,
	wsd_req_if.sink   req,
	wsd_rsp_if.source rsp
);
	import wsd_pkg::*;

	logic     f_valid, f_ready, b_valid, b_ready;
	wsd_cmd_t f_cmd, b_cmd;

	wsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (f_valid),
		.cmd       (f_cmd),
		.cmd_ready (f_ready)
	);

	wsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_cmd   (f_cmd),
		.push_ready (f_ready),
		.pop_valid  (b_valid),
		.pop_cmd    (b_cmd),
		.pop_ready  (b_ready)
	);

	wsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd       (b_cmd),
		.cmd_ready (b_ready),
		.rsp       (rsp)
	);

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_EMPTY |-> rsp.item_count == '0)
		else $error("empty result with items held");

	a_full_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_FULL || rsp.status == ST_EMPTY) |->
		rsp.value_out == '0)
		else $error("refused operation returned a word");

	a_order_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> 32'(rsp.current_order) < 32'(MAX_ORDERS))
		else $error("order beyond largest tier");

	a_queue_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!f_ready |-> b_valid)
		else $error("queue refuses while holding nothing");
endmodule
